@@ design/wah_pkg.sv @@
package wah_pkg;

    // Field widths fixed by the sample format and the register map.
    localparam int SAMPLE_W  = 24;
    localparam int MOD_W     = 16;
    localparam int COEF_W    = 24;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Filter state and datapath widths.
    localparam int Y_W       = 32;          // stored filter output
    localparam int CAP_W     = COEF_W + 1;  // base plus scaled swing
    localparam int DVS_W     = COEF_W + 2;  // p + q + cap, unsigned
    localparam int ACC_W     = 62;          // numerator and all products
    localparam int MAC_CNT_W = $clog2(Y_W);
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam logic [GAIN_W-1:0] GAIN_FLOOR = GAIN_W'(15);

    localparam logic [COEF_W-1:0] RESIST_RST    = COEF_W'(1048576);
    localparam logic [COEF_W-1:0] INDUCT_RST    = COEF_W'(4096);
    localparam logic [COEF_W-1:0] CAP_BASE_RST  = COEF_W'(1048576);
    localparam logic [COEF_W-1:0] CAP_SWING_RST = COEF_W'(6291456);
    localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(154);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESIST    = 3'd0,
        REG_INDUCT    = 3'd1,
        REG_CAP_BASE  = 3'd2,
        REG_CAP_SWING = 3'd3,
        REG_GAIN      = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_CAPSUM,
        ST_PX,
        ST_Y1,
        ST_Y2,
        ST_NUM,
        ST_DIV,
        ST_GAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic mac_run;
        logic mac_load;
        logic acc_clear;
        logic div_start;
        logic out_load;
    } ctrl_t;

endpackage

@@ design/wah_in_if.sv @@
interface wah_in_if import wah_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic        [MOD_W-1:0]    modulation;

    modport source (output valid, output sample_in, output modulation, input ready);
    modport sink   (input valid, input sample_in, input modulation, output ready);
endinterface

@@ design/wah_out_if.sv @@
interface wah_out_if import wah_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ design/wah_div.sv @@
// Restoring divider, one quotient bit per cycle, with the quotient
// truncated toward zero and saturated to the stored output width.
module wah_div import wah_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic        [DVS_W-1:0] den,
    output logic                    done,
    output logic signed [Y_W-1:0]   quot
);

    logic                 busy_reg, busy_next;
    logic                 fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     den_reg;
    logic                 neg_reg;
    logic signed [Y_W-1:0] quot_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [ACC_W-1:0] num_mag;
    logic             over;
    logic signed [Y_W-1:0] sat_val;

    assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign trial   = {rem_reg, quo_reg[ACC_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign fits    = trial >= {1'b0, den_reg};
    assign over    = |quo_reg[ACC_W-1:Y_W];

    always_comb
    begin
        if (den_reg == '0)
        begin
            sat_val = '0;
        end
        else if (neg_reg)
        begin
            if (over || (quo_reg[Y_W-1] && (|quo_reg[Y_W-2:0])))
                sat_val = {1'b1, {(Y_W-1){1'b0}}};
            else
                sat_val = Y_W'(-quo_reg[Y_W-1:0]);
        end
        else
        begin
            if (over || quo_reg[Y_W-1])
                sat_val = {1'b0, {(Y_W-1){1'b1}}};
            else
                sat_val = quo_reg[Y_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ACC_W - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den;
            neg_reg <= num[ACC_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
        if (fin_reg)
            quot_reg <= sat_val;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ design/wah_resonant_filter.sv @@
// Wah resonant filter. Each request on sample_ch carries one signed audio
// sample and a modulation fraction; the block answers with exactly one
// filtered, gain-scaled sample on result_ch. The modulation sweeps the
// capacitor term of a resonant biquad, and the quotient y is kept as the
// filter state in 32 bits. All arithmetic goes through a one-bit-per-cycle
// shift-and-add multiplier and a one-bit-per-cycle restoring divider. A
// sample passes through five multiplies (swing times modulation, the input
// term, the two feedback terms and the output gain), a divide that works
// out a 62-bit quotient, and the sequencing steps (the capacitor sum, the
// divider start and the output step). One sample is in flight at a time; a
// finished result sits in the output register, so the next sample is
// accepted while it waits to be taken. If that result is still waiting when
// the following one is done, the block holds in the output step and takes
// no request until the result moves.
// Configuration writes must be made only while the block is idle.
module wah_resonant_filter import wah_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    wah_in_if.sink               sample_ch,
    wah_out_if.source            result_ch
);

    // Configuration registers.
    logic [COEF_W-1:0] p_reg;
    logic [COEF_W-1:0] q_reg;
    logic [COEF_W-1:0] base_reg;
    logic [COEF_W-1:0] swing_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Filter state.
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic signed [Y_W-1:0]      y1_reg;
    logic signed [Y_W-1:0]      y2_reg;

    // Per-sample working registers.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CAP_W-1:0]           cap_reg;

    // Serial multiplier: the addend shifts left, the multiplier bits
    // shift out at the bottom, and the sign bit weighs negative.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_reg;
    logic [Y_W-1:0]          b_reg;
    logic [MAC_CNT_W-1:0]    cnt_reg;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic                    mac_last;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] acc_step;
    logic signed [ACC_W-1:0] op_a;
    logic [Y_W-1:0]          op_b;

    logic signed [ACC_W-1:0] p_s, q_s, cap_s, xs, neg_aa1, neg_aa2, aa0;
    logic [GAIN_W-1:0]       gain_eff;

    logic                  div_done;
    logic signed [Y_W-1:0] div_y;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] out_sat;
    logic                       out_free;

    // Coefficients of the current sample. These are narrow sums held in the
    // accumulator format so that they load straight into the multiplier.
    assign p_s      = ACC_W'(p_reg);
    assign q_s      = ACC_W'(q_reg);
    assign cap_s    = ACC_W'(cap_reg);
    assign xs       = ACC_W'(x_reg) + (ACC_W'(x1_reg) <<< 1) + ACC_W'(x2_reg);
    assign neg_aa1  = (cap_s <<< 1) - (p_s <<< 1);
    assign neg_aa2  = q_s - p_s - cap_s;
    assign aa0      = p_s + q_s + cap_s;
    assign gain_eff = (gain_reg < GAIN_FLOOR) ? GAIN_FLOOR : gain_reg;

    assign mac_last = (cnt_reg == MAC_CNT_W'(Y_W - 1));
    assign addend   = b_reg[0] ? (mac_last ? -a_reg : a_reg) : '0;
    assign acc_step = acc_reg + addend;

    assign out_free = !out_valid_reg || result_ch.ready;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg     <= RESIST_RST;
            q_reg     <= INDUCT_RST;
            base_reg  <= CAP_BASE_RST;
            swing_reg <= CAP_SWING_RST;
            gain_reg  <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESIST:    p_reg     <= cfg_data[COEF_W-1:0];
                REG_INDUCT:    q_reg     <= cfg_data[COEF_W-1:0];
                REG_CAP_BASE:  base_reg  <= cfg_data[COEF_W-1:0];
                REG_CAP_SWING: swing_reg <= cfg_data[COEF_W-1:0];
                REG_GAIN:      gain_reg  <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (sample_ch.valid) state_next = ST_CAP;
            ST_CAP:    if (mac_last) state_next = ST_CAPSUM;
            ST_CAPSUM: state_next = ST_PX;
            ST_PX:     if (mac_last) state_next = ST_Y1;
            ST_Y1:     if (mac_last) state_next = ST_Y2;
            ST_Y2:     if (mac_last) state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_GAIN;
            ST_GAIN:   if (mac_last) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer: control outputs. Operands load on the edge that enters a
    // multiply; the accumulator is kept across the three numerator terms.
    always_comb
    begin
        ctrl = '0;
        ctrl.in_ready  = (state_reg == ST_IDLE);
        ctrl.mac_run   = (state_reg == ST_CAP) || (state_reg == ST_PX) ||
                         (state_reg == ST_Y1) || (state_reg == ST_Y2) ||
                         (state_reg == ST_GAIN);
        ctrl.mac_load  = (state_next != state_reg) &&
                         ((state_next == ST_CAP) || (state_next == ST_PX) ||
                          (state_next == ST_Y1) || (state_next == ST_Y2) ||
                          (state_next == ST_GAIN));
        ctrl.acc_clear = ctrl.mac_load &&
                         (state_next != ST_Y1) && (state_next != ST_Y2);
        ctrl.div_start = (state_reg == ST_NUM);
        ctrl.out_load  = (state_reg == ST_OUT) && out_free;
    end

    // Operand selection for the multiply being entered.
    always_comb
    begin
        case (state_next)
            ST_CAP:
            begin
                op_a = ACC_W'(swing_reg);
                op_b = Y_W'(sample_ch.modulation);
            end
            ST_PX:
            begin
                op_a = xs;
                op_b = Y_W'(p_reg);
            end
            ST_Y1:
            begin
                op_a = neg_aa1;
                op_b = y1_reg;
            end
            ST_Y2:
            begin
                op_a = neg_aa2;
                op_b = y2_reg;
            end
            ST_GAIN:
            begin
                op_a = ACC_W'(gain_eff);
                op_b = div_y;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.mac_run)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clear)
            acc_reg <= '0;
        else if (ctrl.mac_run)
            acc_reg <= acc_step;

        if (ctrl.mac_load)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (ctrl.mac_run)
        begin
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end

        if (ctrl.in_ready && sample_ch.valid)
            x_reg <= sample_ch.sample_in;

        // Swing times modulation, scaled down by the modulation width.
        if (state_reg == ST_CAPSUM)
            cap_reg <= CAP_W'(base_reg) + CAP_W'(acc_reg[MOD_W +: COEF_W]);
    end

    // Delay line advances once the new filter output is known.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= div_y;
        end
    end

    wah_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (acc_reg),
        .den   (aa0[DVS_W-1:0]),
        .done  (div_done),
        .quot  (div_y)
    );

    // Gain product shifted down by eight (floor) and clipped to the
    // sample range.
    always_comb
    begin
        if ((&acc_reg[ACC_W-1:SAMPLE_W+7]) || !(|acc_reg[ACC_W-1:SAMPLE_W+7]))
            out_sat = acc_reg[SAMPLE_W+7:8];
        else if (acc_reg[ACC_W-1])
            out_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            out_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            out_data_reg <= out_sat;
    end

    assign sample_ch.ready      = ctrl.in_ready;
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_data_reg;

    // An accepted request always starts the modulation multiply.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready |=> state_reg == ST_CAP)
        else $error("accepted request did not start processing");

    // The divider only reports a result while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    // A new result appears only from the output step.
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output step");

    // The multiply step counter is back at zero whenever the block idles.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cnt_reg == '0)
        else $error("multiply step counter left mid-count");

endmodule
